@@ src/mcu_pkg.sv @@
// ----------------------------------------------------------------------------
// Multistage filter package
// Shared constants, register indexes, word types and back-end states.
// ----------------------------------------------------------------------------
package mcu_pkg;

	localparam int NUM_STAGES_DEF  = 4;
	localparam int STAGE_DEPTH_DEF = 1024;
	localparam int COUNT_BITS_DEF  = 32;
	localparam int QUEUE_DEPTH     = 2;
	localparam int CFG_IDX_BITS    = 3;
	localparam int CFG_DATA_BITS   = 64;
	localparam int BYTE_BITS       = 32;
	localparam int KEY_BITS        = 64;
	localparam int NUM_MULTS       = 4;

	localparam logic [31:0] THRESHOLD_RST = 32'd65536;
	localparam logic [63:0] MULT0_RST = 64'd11400714819323198485;
	localparam logic [63:0] MULT1_RST = 64'd14029467366897019727;
	localparam logic [63:0] MULT2_RST = 64'd1609587929392839161;
	localparam logic [63:0] MULT3_RST = 64'd9650029242287828579;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_THRESHOLD = 3'd0,
		REG_MULT0     = 3'd1,
		REG_MULT1     = 3'd2,
		REG_MULT2     = 3'd3,
		REG_MULT3     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic        mode;
		logic [63:0] flow_key;
		logic [31:0] byte_count;
	} pkt_word_t;

	typedef struct packed {
		logic        passed;
		logic [31:0] min_count;
	} verdict_word_t;

	typedef enum logic [2:0] {
		BK_INIT,
		BK_IDLE,
		BK_UPDATE,
		BK_CLEAR,
		BK_FLUSH
	} bk_state_t;

endpackage

@@ src/mcu_stream_if.sv @@
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one word of a given type.
// ----------------------------------------------------------------------------
interface mcu_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ src/mcu_front.sv @@
// ----------------------------------------------------------------------------
// Multistage filter front end
// Accepts packet words and computes the per-stage counter index.
// ----------------------------------------------------------------------------
module mcu_front #(
	parameter int NUM_STAGES  = mcu_pkg::NUM_STAGES_DEF,
	parameter int STAGE_DEPTH = mcu_pkg::STAGE_DEPTH_DEF,
	parameter int IDXW        = $clog2(STAGE_DEPTH),
	parameter int QW          = 1 + mcu_pkg::BYTE_BITS + NUM_STAGES * IDXW
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      hold,
	input  logic [63:0]               mult [mcu_pkg::NUM_MULTS],
	input  logic                      in_valid,
	output logic                      in_ready,
	input  mcu_pkg::pkt_word_t        in_data,
	output logic                      q_valid,
	input  logic                      q_ready,
	output logic [QW-1:0]             q_data
);

	localparam int DW = $clog2(STAGE_DEPTH + 1);
	localparam int PW = 32 + DW;
	localparam logic [DW-1:0] DEPTH_C = DW'(STAGE_DEPTH);

	logic v_s1, v_s2, v_s3, v_s4;
	logic en;
	logic        mode_s1, mode_s2, mode_s3, mode_s4;
	logic [31:0] bytes_s1, bytes_s2, bytes_s3, bytes_s4;
	logic [63:0] key_s1;
	logic [63:0] p0_s2 [NUM_STAGES];
	logic [31:0] p1_s2 [NUM_STAGES];
	logic [31:0] p2_s2 [NUM_STAGES];
	logic [31:0] top_s3 [NUM_STAGES];
	logic [IDXW-1:0] idx_s4 [NUM_STAGES];

	assign en       = !v_s4 || q_ready;
	assign in_ready = en && !hold;
	assign q_valid  = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && in_ready;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1  <= in_data.mode;
			key_s1   <= in_data.flow_key;
			bytes_s1 <= in_data.byte_count;
			mode_s2  <= mode_s1;
			bytes_s2 <= bytes_s1;
			mode_s3  <= mode_s2;
			bytes_s3 <= bytes_s2;
			mode_s4  <= mode_s3;
			bytes_s4 <= bytes_s3;
		end
	end

	// Bits 63:32 of key * multiplier modulo 2^64 from three 32x32 products.
	for (genvar s = 0; s < NUM_STAGES; s++) begin : g_lane
		logic [63:0] m;
		logic [63:0] lo_prod, hi_a, hi_b;
		logic [PW-1:0] scaled;

		assign m       = mult[s % mcu_pkg::NUM_MULTS] ^ (64'(s / mcu_pkg::NUM_MULTS) << 1);
		assign lo_prod = 64'(key_s1[31:0]) * 64'(m[31:0]);
		assign hi_a    = 64'(key_s1[31:0]) * 64'(m[63:32]);
		assign hi_b    = 64'(key_s1[63:32]) * 64'(m[31:0]);
		assign scaled  = PW'(top_s3[s]) * PW'(DEPTH_C);

		always_ff @(posedge clk) begin
			if (en) begin
				p0_s2[s]  <= lo_prod;
				p1_s2[s]  <= hi_a[31:0];
				p2_s2[s]  <= hi_b[31:0];
				top_s3[s] <= p0_s2[s][63:32] + p1_s2[s] + p2_s2[s];
				idx_s4[s] <= scaled[32 +: IDXW];
			end
		end

		assign q_data[1 + 32 + s * IDXW +: IDXW] = idx_s4[s];
	end

	assign q_data[0]    = mode_s4;
	assign q_data[32:1] = bytes_s4;

endmodule

@@ src/mcu_fifo.sv @@
// ----------------------------------------------------------------------------
// Multistage filter queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module mcu_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = mcu_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             not_full,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_push, do_pop;

	assign not_full  = count_q != CNTW'(DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && not_full;
	assign do_pop    = pop && not_empty;
	assign rdata     = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTRW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTRW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + CNTW'(do_push) - CNTW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= wdata;
	end

endmodule

@@ src/mcu_back.sv @@
// ----------------------------------------------------------------------------
// Multistage filter back end
// Counter memories, threshold test, conservative update and result register.
// ----------------------------------------------------------------------------
module mcu_back #(
	parameter int NUM_STAGES  = mcu_pkg::NUM_STAGES_DEF,
	parameter int STAGE_DEPTH = mcu_pkg::STAGE_DEPTH_DEF,
	parameter int COUNT_BITS  = mcu_pkg::COUNT_BITS_DEF,
	parameter int IDXW        = $clog2(STAGE_DEPTH),
	parameter int QW          = 1 + mcu_pkg::BYTE_BITS + NUM_STAGES * IDXW
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [31:0]           threshold,
	output logic                  init_busy,
	input  logic                  q_valid,
	output logic                  q_pop,
	input  logic [QW-1:0]         q_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output mcu_pkg::verdict_word_t out_data
);

	localparam int CW = (COUNT_BITS > 32) ? COUNT_BITS : 32;
	localparam logic [CW:0] CMAX = (CW + 1)'({COUNT_BITS{1'b1}});

	mcu_pkg::bk_state_t state_q, state_d;

	logic [IDXW-1:0]       cnt_q;
	logic [IDXW-1:0]       cur_idx_q [NUM_STAGES];
	logic [31:0]           bytes_q;
	logic                  mode_q;
	logic [COUNT_BITS-1:0] rd_s1 [NUM_STAGES];
	logic                  slot_free, last_addr;
	logic                  wr_en, wr_clear, load_out, cnt_inc;
	logic                  pass;
	logic [CW-1:0]         minv;
	logic [CW:0]           cap_sum, cap;
	logic                  out_v_q;
	mcu_pkg::verdict_word_t out_q;

	assign slot_free = !out_v_q || out_ready;
	assign last_addr = cnt_q == IDXW'(STAGE_DEPTH - 1);
	assign init_busy = state_q == mcu_pkg::BK_INIT;

	always_comb begin
		state_d = state_q;
		case (state_q)
			mcu_pkg::BK_INIT:   if (last_addr) state_d = mcu_pkg::BK_IDLE;
			mcu_pkg::BK_IDLE:   if (q_valid) state_d = q_data[0] ? mcu_pkg::BK_CLEAR
				: mcu_pkg::BK_UPDATE;
			mcu_pkg::BK_UPDATE: if (slot_free) state_d = mcu_pkg::BK_IDLE;
			mcu_pkg::BK_CLEAR:  if (last_addr) state_d = mcu_pkg::BK_FLUSH;
			mcu_pkg::BK_FLUSH:  if (slot_free) state_d = mcu_pkg::BK_IDLE;
			default:            state_d = mcu_pkg::BK_INIT;
		endcase
	end

	always_comb begin
		q_pop    = 1'b0;
		wr_en    = 1'b0;
		wr_clear = 1'b0;
		load_out = 1'b0;
		cnt_inc  = 1'b0;
		case (state_q)
			mcu_pkg::BK_INIT: begin
				wr_clear = 1'b1;
				cnt_inc  = 1'b1;
			end
			mcu_pkg::BK_IDLE:   q_pop = q_valid;
			mcu_pkg::BK_UPDATE: begin
				wr_en    = slot_free;
				load_out = slot_free;
			end
			mcu_pkg::BK_CLEAR: begin
				wr_clear = 1'b1;
				cnt_inc  = 1'b1;
			end
			mcu_pkg::BK_FLUSH:  load_out = slot_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcu_pkg::BK_INIT;
			cnt_q   <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cnt_inc)
				cnt_q <= last_addr ? '0 : cnt_q + 1'b1;
			if (load_out)
				out_v_q <= 1'b1;
			else if (out_ready)
				out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			mode_q  <= q_data[0];
			bytes_q <= q_data[32:1];
		end
		if (load_out) begin
			out_q.passed    <= !mode_q && pass;
			out_q.min_count <= mode_q ? '0 : ((minv > CW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
				: minv[31:0]);
		end
	end

	// Smallest counter over all stages and the all-stages pass test.
	always_comb begin
		minv = CW'(rd_s1[0]);
		pass = 1'b1;
		for (int s = 0; s < NUM_STAGES; s++) begin
			if (CW'(rd_s1[s]) < minv)
				minv = CW'(rd_s1[s]);
			if (!((CW + 1)'(rd_s1[s]) + (CW + 1)'(bytes_q) > (CW + 1)'(threshold)))
				pass = 1'b0;
		end
	end

	assign cap_sum = (CW + 1)'(minv) + (CW + 1)'(bytes_q);
	assign cap     = (cap_sum > CMAX) ? CMAX : cap_sum;

	for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
		logic [COUNT_BITS-1:0] mem [STAGE_DEPTH];
		logic [IDXW-1:0]       rd_addr;
		logic [CW:0]           sum, sat, nxt;
		logic                  below;

		assign rd_addr = q_pop ? q_data[1 + 32 + s * IDXW +: IDXW] : cur_idx_q[s];
		assign sum     = (CW + 1)'(rd_s1[s]) + (CW + 1)'(bytes_q);
		assign sat     = (sum > CMAX) ? CMAX : sum;
		assign nxt     = (sat > cap) ? cap : sat;
		assign below   = CW'(rd_s1[s]) < CW'(threshold);

		always_ff @(posedge clk) begin
			if (q_pop)
				cur_idx_q[s] <= q_data[1 + 32 + s * IDXW +: IDXW];
			if (wr_clear)
				mem[cnt_q] <= '0;
			else if (wr_en && !pass && below)
				mem[cur_idx_q[s]] <= nxt[COUNT_BITS-1:0];
			rd_s1[s] <= mem[rd_addr];
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

endmodule

@@ src/multistage_filter_conservative_update.sv @@
// ----------------------------------------------------------------------------
// Multistage filter with conservative update
// Heavy-flow detector: hashed per-stage byte counters with a threshold test.
// ----------------------------------------------------------------------------
// Packet words arrive on the pkt channel (mode, flow_key, byte_count) and one
// verdict word per packet word leaves on the verdict channel (passed,
// min_count), in order. Both channels use valid/ready; a word moves at a rising
// edge where both are high.
// The front end registers the word, forms three 32x32 partial products per
// stage, sums them into the top half of the 64-bit hash product and scales it
// to a counter index, each step in its own register stage; it takes one word
// per cycle while the queue has room and no counter sweep holds the input. A
// two-entry queue then feeds the back end, which reads all stage counters
// together as it takes a word and writes the conservative update once the
// output register is free, taking the next word only after that write, set
// by the read-then-write on the counter memories. A clear word sweeps every
// counter address before its verdict. After reset the counters are swept to
// zero, during which pkt.ready stays low; configuration writes are taken
// throughout. When the receiver stalls, the verdict holds in the output
// register while the queue and front end keep taking words until they fill.
// The user is to write configuration through cfg_we/cfg_index/cfg_data only
// while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module multistage_filter_conservative_update #(
	parameter int NUM_STAGES  = mcu_pkg::NUM_STAGES_DEF,
	parameter int STAGE_DEPTH = mcu_pkg::STAGE_DEPTH_DEF,
	parameter int COUNT_BITS  = mcu_pkg::COUNT_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mcu_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [mcu_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	mcu_stream_if.sink                         pkt,
	mcu_stream_if.source                       verdict
);

	localparam int IDXW = $clog2(STAGE_DEPTH);
	localparam int QW   = 1 + mcu_pkg::BYTE_BITS + NUM_STAGES * IDXW;

	// Configuration registers: threshold and the four hash multipliers.
	logic [31:0] threshold_q;
	logic [63:0] mult_q [mcu_pkg::NUM_MULTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= mcu_pkg::THRESHOLD_RST;
			mult_q[0]   <= mcu_pkg::MULT0_RST;
			mult_q[1]   <= mcu_pkg::MULT1_RST;
			mult_q[2]   <= mcu_pkg::MULT2_RST;
			mult_q[3]   <= mcu_pkg::MULT3_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				mcu_pkg::REG_THRESHOLD: threshold_q <= cfg_data[31:0];
				mcu_pkg::REG_MULT0:     mult_q[0]   <= cfg_data;
				mcu_pkg::REG_MULT1:     mult_q[1]   <= cfg_data;
				mcu_pkg::REG_MULT2:     mult_q[2]   <= cfg_data;
				mcu_pkg::REG_MULT3:     mult_q[3]   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic          init_busy;
	logic          fq_valid, fq_ready, bq_valid, bq_pop;
	logic [QW-1:0] fq_data, bq_data;

	mcu_front #(
		.NUM_STAGES(NUM_STAGES), .STAGE_DEPTH(STAGE_DEPTH), .IDXW(IDXW), .QW(QW)
	) u_front (
		.clk(clk), .arst_n(arst_n), .hold(init_busy), .mult(mult_q),
		.in_valid(pkt.valid), .in_ready(pkt.ready), .in_data(pkt.data),
		.q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
	);

	// Queue between the hashing front end and the counter back end.
	mcu_fifo #(.WIDTH(QW), .DEPTH(mcu_pkg::QUEUE_DEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(fq_valid), .not_full(fq_ready), .wdata(fq_data),
		.pop(bq_pop), .not_empty(bq_valid), .rdata(bq_data)
	);

	mcu_back #(
		.NUM_STAGES(NUM_STAGES), .STAGE_DEPTH(STAGE_DEPTH), .COUNT_BITS(COUNT_BITS),
		.IDXW(IDXW), .QW(QW)
	) u_back (
		.clk(clk), .arst_n(arst_n), .threshold(threshold_q), .init_busy(init_busy),
		.q_valid(bq_valid), .q_pop(bq_pop), .q_data(bq_data),
		.out_valid(verdict.valid), .out_ready(verdict.ready), .out_data(verdict.data)
	);

endmodule

@@ src/mcu_checker.sv @@
// ----------------------------------------------------------------------------
// Multistage filter checker
// Port-level checks on ordering, occupancy and reset behaviour.
// ----------------------------------------------------------------------------
module mcu_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          pkt_valid,
	input logic                          pkt_ready,
	input logic                          verdict_valid,
	input logic                          verdict_ready,
	input mcu_pkg::verdict_word_t        verdict_data
);

	logic [3:0] pending_q;
	logic       in_acc, out_acc;

	assign in_acc  = pkt_valid && pkt_ready;
	assign out_acc = verdict_valid && verdict_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pending_q <= '0;
		else
			pending_q <= pending_q + 4'(in_acc) - 4'(out_acc);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		verdict_valid && !verdict_ready |=> verdict_valid && $stable(verdict_data))
		else $error("verdict word changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> pending_q != 4'd0)
		else $error("verdict word without a packet word");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 4'd8)
		else $error("too many words in flight");

	a_init: assert property (@(posedge clk)
		!$past(arst_n) && arst_n |-> !pkt_ready)
		else $error("packet word taken during counter sweep");

endmodule

bind multistage_filter_conservative_update mcu_checker u_checker (
	.clk(clk), .arst_n(arst_n),
	.pkt_valid(pkt.valid), .pkt_ready(pkt.ready),
	.verdict_valid(verdict.valid), .verdict_ready(verdict.ready),
	.verdict_data(verdict.data)
);

@@ dv/tb_multistage_filter_conservative_update.sv @@
// ----------------------------------------------------------------------------
// Multistage filter testbench
// Drives packet and clear words into the filter with random gaps on both
// channels, predicts each verdict from a model of the hashed counters and
// compares the verdicts in order.
// ----------------------------------------------------------------------------
module tb_multistage_filter_conservative_update;

	localparam int NSTG  = mcu_pkg::NUM_STAGES_DEF;
	localparam int DEPTH = mcu_pkg::STAGE_DEPTH_DEF;
	localparam longint unsigned CYCLE_LIMIT = 2000000;

	// Scoreboard: holds its own copy of the counters and registers, and the
	// queue of verdict words still to come.
	class filter_scoreboard;
		logic [31:0]            thresh;
		logic [63:0]            mult [mcu_pkg::NUM_MULTS];
		logic [31:0]            counters [NSTG*DEPTH];
		mcu_pkg::verdict_word_t pending [$];
		int                     mismatches;

		function void reset_state();
			thresh  = mcu_pkg::THRESHOLD_RST;
			mult[0] = mcu_pkg::MULT0_RST;
			mult[1] = mcu_pkg::MULT1_RST;
			mult[2] = mcu_pkg::MULT2_RST;
			mult[3] = mcu_pkg::MULT3_RST;
			foreach (counters[i]) counters[i] = '0;
			pending.delete();
			mismatches = 0;
		endfunction

		function void write_reg(mcu_pkg::reg_idx_t idx, logic [63:0] value);
			case (idx)
				mcu_pkg::REG_THRESHOLD: thresh = value[31:0];
				mcu_pkg::REG_MULT0:     mult[0] = value;
				mcu_pkg::REG_MULT1:     mult[1] = value;
				mcu_pkg::REG_MULT2:     mult[2] = value;
				mcu_pkg::REG_MULT3:     mult[3] = value;
				default: ;
			endcase
		endfunction

		// Multiply-shift hash: for a power-of-two depth the index is the top
		// bits of the low 64 bits of the product.
		function int counter_slot(int stg, logic [63:0] key);
			logic [63:0] m;
			logic [63:0] prod;
			m = mult[stg % 4] ^ (64'(stg / 4) << 1);
			prod = key * m;
			return stg * DEPTH + int'(prod[63:64-$clog2(DEPTH)]);
		endfunction

		function void note_packet(mcu_pkg::pkt_word_t w);
			mcu_pkg::verdict_word_t v;
			int                     slot [NSTG];
			logic [32:0]            low, cap, sum;
			logic                   pass;
			if (w.mode) begin
				foreach (counters[i]) counters[i] = '0;
				v = '0;
				pending.push_back(v);
				return;
			end
			low  = 33'h1_0000_0000;
			pass = 1'b1;
			for (int s = 0; s < NSTG; s++) begin
				slot[s] = counter_slot(s, w.flow_key);
				// The sum is taken exactly, so it never wraps here.
				if ({1'b0, counters[slot[s]]} + w.byte_count <= {1'b0, thresh})
					pass = 1'b0;
				if (counters[slot[s]] < low) low = counters[slot[s]];
			end
			if (!pass) begin
				cap = low + w.byte_count;
				if (cap[32]) cap = 33'hFFFF_FFFF;
				for (int s = 0; s < NSTG; s++) begin
					if (counters[slot[s]] < thresh) begin
						sum = counters[slot[s]] + w.byte_count;
						if (sum[32]) sum = 33'hFFFF_FFFF;
						counters[slot[s]] = (sum > cap) ? cap[31:0] : sum[31:0];
					end
				end
			end
			v.passed    = pass;
			v.min_count = low[31:0];
			pending.push_back(v);
		endfunction

		function void check_verdict(mcu_pkg::verdict_word_t got);
			mcu_pkg::verdict_word_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected verdict: passed=%0b min_count=%0d",
						got.passed, got.min_count);
				return;
			end
			want = pending.pop_front();
			if (got.passed !== want.passed || got.min_count !== want.min_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"Verdict mismatch: expected passed=%0b min_count=%0d,",
						" got passed=%0b min_count=%0d"},
						want.passed, want.min_count, got.passed, got.min_count);
			end
		endfunction
	endclass

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [mcu_pkg::CFG_IDX_BITS-1:0]  cfg_index;
	logic [mcu_pkg::CFG_DATA_BITS-1:0] cfg_data;
	longint unsigned                   cycles;
	logic                              stim_done;

	mcu_stream_if #(.T(mcu_pkg::pkt_word_t))     pkt_ch ();
	mcu_stream_if #(.T(mcu_pkg::verdict_word_t)) verdict_ch ();

	filter_scoreboard sb;

	multistage_filter_conservative_update u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pkt       (pkt_ch.sink),
		.verdict   (verdict_ch.source)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The run is ended by the cycle counter should the block hang.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// The receiver draws a stall for every verdict word and samples at the
	// rising edge; ready changes only at the falling edge.
	initial begin
		int wait_n;
		verdict_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
			if (wait_n > 0) begin
				verdict_ch.ready <= 1'b0;
				repeat (wait_n) @(negedge clk);
			end
			verdict_ch.ready <= 1'b1;
			do @(posedge clk); while (!verdict_ch.valid);
			sb.check_verdict(verdict_ch.data);
		end
	end

	// Sends one word after a gap drawn for it. In a burst the gap is zero,
	// so valid stays high from one word to the next.
	bit burst;

	task automatic send_word(logic m, logic [63:0] key, logic [31:0] bytes);
		int gap;
		mcu_pkg::pkt_word_t w;
		gap = burst ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		w.mode = m;
		w.flow_key = key;
		w.byte_count = bytes;
		pkt_ch.valid <= 1'b1;
		pkt_ch.data  <= w;
		do @(posedge clk); while (!pkt_ch.ready);
		sb.note_packet(w);
		@(negedge clk);
	endtask

	// Lowers valid and waits until every verdict has come back.
	task automatic drain();
		pkt_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending.size() != 0) @(negedge clk);
		// Let the output register and queue settle before any register write.
		repeat (20) @(negedge clk);
	endtask

	// One write per call; the task waits with the enable low before returning,
	// so that the enable is lowered and raised at different falling edges.
	task automatic write_cfg(mcu_pkg::reg_idx_t idx, logic [63:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, value);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Byte counts are mostly small so that counters climb across the
	// threshold over several packets, with the odd extreme mixed in.
	function automatic logic [31:0] rand_bytes();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
			default: return $urandom_range(0, 4000);
		endcase
	endfunction

	logic [63:0] flows [16];

	// One phase of random traffic: a small pool of heavy flows with noise.
	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			burst = ($urandom_range(0, 7) == 0) ? ~burst : burst;
			if ($urandom_range(0, 59) == 0)
				send_word(1'b1, rand64(), $urandom());
			else if ($urandom_range(0, 3) == 0)
				send_word(1'b0, rand64(), rand_bytes());
			else
				send_word(1'b0, flows[$urandom_range(0, 15)], rand_bytes());
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		cycles       = 0;
		stim_done    = 1'b0;
		burst        = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		pkt_ch.valid = 1'b0;
		pkt_ch.data  = '0;
		arst_n       = 1'b0;
		foreach (flows[i]) flows[i] = rand64();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words under the reset registers: the extremes of key and
		// byte count, a repeated flow that crosses the threshold, and clear
		// mode with junk in the other fields.
		send_word(1'b0, 64'h0, 32'h0);
		send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1);
		for (int i = 0; i < 6; i++) send_word(1'b0, 64'h1234_5678_9ABC_DEF0, 32'd20000);
		send_word(1'b0, 64'h1234_5678_9ABC_DEF0, 32'd65536);
		send_word(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_word(1'b0, 64'h1234_5678_9ABC_DEF0, 32'd10);
		send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd65536);
		send_word(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
		drain();

		// A zero threshold lets everything with bytes through; the largest one
		// passes a word only when each stage sum overflows 32 bits, and counters
		// saturate. Even and all-ones multipliers are written as well.
		write_cfg(mcu_pkg::REG_THRESHOLD, 64'h0);
		write_cfg(mcu_pkg::REG_MULT0, 64'h1);
		write_cfg(mcu_pkg::REG_MULT1, 64'hFFFF_FFFF_FFFF_FFFF);
		write_cfg(mcu_pkg::REG_MULT2, 64'h2);
		write_cfg(mcu_pkg::REG_MULT3, 64'h8000_0000_0000_0000);
		send_word(1'b0, 64'h7, 32'h0);
		send_word(1'b0, 64'h7, 32'h1);
		random_phase(60);
		drain();

		write_cfg(mcu_pkg::REG_THRESHOLD, 64'hFFFF_FFFF);
		random_phase(100);
		drain();

		// Random multipliers and a modest threshold for the bulk of the run.
		write_cfg(mcu_pkg::REG_THRESHOLD, 64'(($urandom_range(2000, 40000))));
		write_cfg(mcu_pkg::REG_MULT0, rand64() | 64'h1);
		write_cfg(mcu_pkg::REG_MULT1, rand64() | 64'h1);
		write_cfg(mcu_pkg::REG_MULT2, rand64());
		write_cfg(mcu_pkg::REG_MULT3, rand64() | 64'h1);
		random_phase(220);
		drain();

		write_cfg(mcu_pkg::REG_THRESHOLD, 64'({$urandom()} | 64'hFFFF_FFFF_0000_0000));
		write_cfg(mcu_pkg::REG_MULT0, mcu_pkg::MULT0_RST);
		write_cfg(mcu_pkg::REG_MULT2, mcu_pkg::MULT2_RST);
		write_cfg(mcu_pkg::REG_THRESHOLD, 64'd65536);
		random_phase(200);

		pkt_ch.valid <= 1'b0;
		stim_done = 1'b1;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/mcu_pkg.sv
src/mcu_stream_if.sv
src/mcu_front.sv
src/mcu_fifo.sv
src/mcu_back.sv
src/multistage_filter_conservative_update.sv
src/mcu_checker.sv
dv/tb_multistage_filter_conservative_update.sv
